// ===== sv/frontier_cell_selector_defines.svh =====
// Assertion macros for the frontier cell selector checker.
// Depends on nothing; included by files that assert.
`ifndef FRONTIER_CELL_SELECTOR_DEFINES_SVH
`define FRONTIER_CELL_SELECTOR_DEFINES_SVH

// same-cycle implication
`define FCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/fcs_pkg.sv =====
// Shared types, constants and helpers of the frontier cell selector.
// Depends on nothing; used by every other file of the block but the assertion macro header.
package fcs_pkg;

	localparam int GRID_DIM = 16;
	localparam int ADDR_W   = $clog2(GRID_DIM);
	localparam int POS_W    = 4;
	localparam int CRD_W    = ((ADDR_W > POS_W) ? ADDR_W : POS_W) + 2;
	localparam int SCORE_W  = 4;
	localparam int WIN      = 5;
	localparam int SLOT_W   = $clog2(WIN);
	localparam int NBR_N    = 8;
	localparam int NBR_W    = $clog2(NBR_N);

	typedef logic [GRID_DIM-1:0]     row_t;
	typedef logic [ADDR_W-1:0]       addr_t;
	typedef logic signed [CRD_W-1:0] crd_t;
	typedef logic [SCORE_W-1:0]      score_t;

	typedef enum logic [1:0] {
		REQ_MARK    = 2'd0,
		REQ_PLAN    = 2'd1,
		REQ_RESTART = 2'd2,
		REQ_NOP     = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_SCORE,
		ST_MARK_RD,
		ST_MARK_WR,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic  rd_en;
		addr_t rd_addr;
		logic  wr_en;
		addr_t wr_addr;
		row_t  wr_data;
		logic  clear;
	} map_cmd_t;

	function automatic row_t reset_row(addr_t a);
		row_t r;
		r = '0;
		if (a == '0) begin
			r[0] = 1'b1;
		end
		return r;
	endfunction

	function automatic logic in_grid(crd_t c);
		return (c >= 0) && (c < crd_t'(GRID_DIM));
	endfunction

	// neighbor offsets in row-major scan order, center skipped
	function automatic int nbr_dx(logic [NBR_W-1:0] n);
		int d;
		case (n)
			3'd0, 3'd3, 3'd5: d = -1;
			3'd1, 3'd6:       d = 0;
			default:          d = 1;
		endcase
		return d;
	endfunction

	function automatic int nbr_dy(logic [NBR_W-1:0] n);
		int d;
		case (n)
			3'd0, 3'd1, 3'd2: d = -1;
			3'd3, 3'd4:       d = 0;
			default:          d = 1;
		endcase
		return d;
	endfunction

endpackage

// ===== sv/fcs_req_if.sv =====
// Request channel of the frontier cell selector: valid/ready plus request word.
// Depends on fcs_pkg.
interface fcs_req_if;
	import fcs_pkg::*;

	logic             valid;
	logic             ready;
	logic [1:0]       req_type;
	logic [POS_W-1:0] cell_x;
	logic [POS_W-1:0] cell_y;

	modport source (output valid, req_type, cell_x, cell_y, input ready);
	modport sink (input valid, req_type, cell_x, cell_y, output ready);
endinterface

// ===== sv/fcs_res_if.sv =====
// Result channel of the frontier cell selector: valid/ready plus result word.
// Depends on fcs_pkg.
interface fcs_res_if;
	import fcs_pkg::*;

	logic               valid;
	logic               ready;
	logic               found;
	logic [POS_W-1:0]   next_x;
	logic [POS_W-1:0]   next_y;
	logic [SCORE_W-1:0] best_score;

	modport source (output valid, found, next_x, next_y, best_score, input ready);
	modport sink (input valid, found, next_x, next_y, best_score, output ready);
endinterface

// ===== sv/fcs_map_store.sv =====
// Explored-map row memory with per-row valid bits and a registered read.
// Depends on fcs_pkg.
module fcs_map_store (
	input  logic              clk,
	input  logic              arst_n,
	input  fcs_pkg::map_cmd_t cmd,
	output fcs_pkg::row_t     rd_row
);
	import fcs_pkg::*;

	row_t                mem [GRID_DIM];
	logic [GRID_DIM-1:0] row_vld_q;
	row_t                rd_data_s1;
	addr_t               rd_addr_s1;
	logic                rd_vld_s1;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[cmd.wr_addr] <= cmd.wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_s1 <= mem[cmd.rd_addr];
			rd_addr_s1 <= cmd.rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (cmd.clear) begin
				row_vld_q <= '0;
			end else if (cmd.wr_en) begin
				row_vld_q[cmd.wr_addr] <= 1'b1;
			end
			if (cmd.rd_en) begin
				rd_vld_s1 <= row_vld_q[cmd.rd_addr];
			end
		end
	end

	// unwritten rows read as their restart value
	assign rd_row = rd_vld_s1 ? rd_data_s1 : reset_row(rd_addr_s1);

endmodule

// ===== sv/frontier_cell_selector.sv =====
// Top level of the frontier cell selector: control sequencer, 5x5 window, scoring.
// Depends on fcs_pkg, fcs_req_if, fcs_res_if and fcs_map_store.

// One request is taken at a time and each gives exactly one result word. A plan
// reads the map from a row memory with a single read port: the five rows around
// the position are read one per cycle into a 5x5 window, followed by a window
// load step, a scoring step and a pick step that fills the output register once
// it is free or being emptied. A mark is a read-modify-write of one row; restart
// and no-op go straight to the result step. Restart clears the per-row valid bits
// at once, so there is no clearing pass after reset. The next request may be
// accepted while the previous result still waits to be taken.
module frontier_cell_selector (
	input logic       clk,
	input logic       arst_n,
	fcs_req_if.sink   req,
	fcs_res_if.source res
);
	import fcs_pkg::*;

	state_t                 state_q;
	state_t                 state_d;
	req_t                   req_q;
	logic [POS_W-1:0]       px_q;
	logic [POS_W-1:0]       py_q;
	logic [SLOT_W-1:0]      cnt_q;
	logic                   rd_pend_s1;
	logic [SLOT_W-1:0]      rd_slot_s1;
	logic                   rd_ok_s1;
	logic [WIN-1:0][WIN-1:0] win_q;
	score_t                 score_q [NBR_N];
	score_t                 score_d [NBR_N];
	logic                   out_valid_q;
	logic                   found_q;
	logic [POS_W-1:0]       next_x_q;
	logic [POS_W-1:0]       next_y_q;
	score_t                 best_score_q;

	map_cmd_t               cmd;
	row_t                   rd_row;
	crd_t                   px_c;
	crd_t                   py_c;
	crd_t                   row_c;
	crd_t                   col_c [WIN];
	logic [WIN-1:0]         col_ok;
	logic [NBR_N-1:0]       nbr_ok;
	logic                   accept;
	logic                   can_load;
	logic                   fin_load;
	logic                   mark_ok;
	row_t                   mark_bit;
	score_t                 pick_score;
	logic [NBR_W-1:0]       pick_n;

	fcs_map_store u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rd_row (rd_row)
	);

	assign px_c     = crd_t'(px_q);
	assign py_c     = crd_t'(py_q);
	assign row_c    = py_c + crd_t'(cnt_q) - crd_t'(2);
	assign accept   = req.valid && req.ready;
	assign can_load = !out_valid_q || res.ready;
	assign mark_ok  = in_grid(crd_t'(req.cell_x)) && in_grid(crd_t'(req.cell_y));

	always_comb begin
		for (int k = 0; k < WIN; k++) begin
			col_c[k]  = px_c + crd_t'(k) - crd_t'(2);
			col_ok[k] = in_grid(col_c[k]);
		end
		for (int n = 0; n < NBR_N; n++) begin
			nbr_ok[n] = in_grid(px_c + crd_t'(nbr_dx(NBR_W'(n))))
				&& in_grid(py_c + crd_t'(nbr_dy(NBR_W'(n))));
		end
	end

	always_comb begin
		mark_bit = '0;
		mark_bit[addr_t'(px_q)] = 1'b1;
	end

	// score each unexplored in-grid neighbor by its explored neighbors
	always_comb begin
		int dx;
		int dy;
		int s;
		for (int n = 0; n < NBR_N; n++) begin
			dx = nbr_dx(NBR_W'(n));
			dy = nbr_dy(NBR_W'(n));
			s = 0;
			for (int i = -1; i <= 1; i++) begin
				for (int j = -1; j <= 1; j++) begin
					if (!(i == 0 && j == 0)) begin
						s = s + int'(win_q[2+dy+i][2+dx+j]);
					end
				end
			end
			score_d[n] = (nbr_ok[n] && !win_q[2+dy][2+dx]) ? SCORE_W'(s) : '0;
		end
	end

	// last highest nonzero score in scan order wins
	always_comb begin
		pick_score = '0;
		pick_n     = '0;
		for (int n = 0; n < NBR_N; n++) begin
			if (score_q[n] != '0 && score_q[n] >= pick_score) begin
				pick_score = score_q[n];
				pick_n     = NBR_W'(n);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					case (req.req_type)
						REQ_MARK: state_d = mark_ok ? ST_MARK_RD : ST_FINISH;
						REQ_PLAN: state_d = ST_READ;
						default:  state_d = ST_FINISH;
					endcase
				end
			end
			ST_READ: begin
				if (cnt_q == SLOT_W'(WIN - 1)) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD:    state_d = ST_SCORE;
			ST_SCORE:   state_d = ST_FINISH;
			ST_MARK_RD: state_d = ST_MARK_WR;
			ST_MARK_WR: state_d = ST_FINISH;
			ST_FINISH: begin
				if (can_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req.ready = 1'b0;
		fin_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				cmd.clear = req.valid && (req.req_type == REQ_RESTART);
			end
			ST_READ: begin
				cmd.rd_en   = in_grid(row_c);
				cmd.rd_addr = addr_t'(row_c);
			end
			ST_MARK_RD: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = addr_t'(py_q);
			end
			ST_MARK_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_addr = addr_t'(py_q);
				cmd.wr_data = rd_row | mark_bit;
			end
			ST_FINISH: fin_load = can_load;
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rd_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_pend_s1 <= (state_q == ST_READ);
			if (accept) begin
				cnt_q <= '0;
			end else if (state_q == ST_READ) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (fin_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_t'(req.req_type);
			px_q  <= req.cell_x;
			py_q  <= req.cell_y;
		end
		if (state_q == ST_READ) begin
			rd_slot_s1 <= cnt_q;
			rd_ok_s1   <= in_grid(row_c);
		end
		if (rd_pend_s1) begin
			for (int k = 0; k < WIN; k++) begin
				win_q[rd_slot_s1][k] <= rd_ok_s1 && col_ok[k] && rd_row[addr_t'(col_c[k])];
			end
		end
		if (state_q == ST_SCORE) begin
			score_q <= score_d;
		end
		if (fin_load) begin
			if (req_q == REQ_PLAN && pick_score != '0) begin
				found_q      <= 1'b1;
				next_x_q     <= POS_W'(px_c + crd_t'(nbr_dx(pick_n)));
				next_y_q     <= POS_W'(py_c + crd_t'(nbr_dy(pick_n)));
				best_score_q <= pick_score;
			end else begin
				found_q      <= 1'b0;
				next_x_q     <= '0;
				next_y_q     <= '0;
				best_score_q <= '0;
			end
		end
	end

	assign res.valid      = out_valid_q;
	assign res.found      = found_q;
	assign res.next_x     = next_x_q;
	assign res.next_y     = next_y_q;
	assign res.best_score = best_score_q;

endmodule

// ===== sv/fcs_checker.sv =====
// Port-level checker of the frontier cell selector and its bind to the top level.
// Depends on fcs_pkg and frontier_cell_selector_defines.svh.
`include "frontier_cell_selector_defines.svh"

module fcs_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic                        found,
	input logic [fcs_pkg::POS_W-1:0]   next_x,
	input logic [fcs_pkg::POS_W-1:0]   next_y,
	input logic [fcs_pkg::SCORE_W-1:0] best_score
);
	import fcs_pkg::*;

	`FCS_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid, "result word dropped")
	`FCS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req_valid && req_ready, !req_ready, "ready after accept")
	`FCS_ASSERT_NOW(a_miss_zero, clk, arst_n, res_valid && !found, next_x == '0 && next_y == '0 && best_score == '0, "miss word not zero")
	`FCS_ASSERT_NOW(a_hit_score, clk, arst_n, res_valid && found, best_score != '0 && best_score <= SCORE_W'(NBR_N), "hit score out of range")

endmodule

bind frontier_cell_selector fcs_checker u_fcs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.found      (res.found),
	.next_x     (res.next_x),
	.next_y     (res.next_y),
	.best_score (res.best_score)
);

// ===== sim/frontier_cell_selector_checker.sv =====
`timescale 1ns / 1ps
// Checker of the frontier cell selector: watches the request and result channels,
// keeps its own copy of the explored map and compares every result word.
// Depends on fcs_pkg, fcs_req_if and fcs_res_if.
module frontier_cell_selector_checker
	import fcs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	fcs_req_if   req,
	fcs_res_if   res,
	output int   pending,
	output int   fail_count
);

	typedef struct packed {
		logic               found;
		logic [POS_W-1:0]   next_x;
		logic [POS_W-1:0]   next_y;
		logic [SCORE_W-1:0] best_score;
	} answer_t;

	row_t    explored_rows [GRID_DIM];
	answer_t expected_answers [$];

	function automatic logic on_map(int x, int y);
		return x >= 0 && y >= 0 && x < GRID_DIM && y < GRID_DIM;
	endfunction

	function automatic void clear_explored();
		foreach (explored_rows[i]) explored_rows[i] = '0;
		explored_rows[0][0] = 1'b1;
	endfunction

	function automatic int explored_ring(int cx, int cy);
		int n, dx, dy;
		n = 0;
		for (dy = -1; dy <= 1; dy++) begin
			for (dx = -1; dx <= 1; dx++) begin
				if ((dx != 0 || dy != 0) && on_map(cx + dx, cy + dy))
					n += explored_rows[cy + dy][cx + dx];
			end
		end
		return n;
	endfunction

	// apply one request to the map and return the answer it earns
	function automatic answer_t serve_request(req_t kind, int px, int py);
		answer_t a;
		int best, s, x, y, dx, dy;
		a = '0;
		best = 0;
		case (kind)
			REQ_MARK: begin
				if (on_map(px, py))
					explored_rows[py][px] = 1'b1;
			end
			REQ_RESTART: begin
				clear_explored();
			end
			REQ_PLAN: begin
				for (dy = -1; dy <= 1; dy++) begin
					for (dx = -1; dx <= 1; dx++) begin
						x = px + dx;
						y = py + dy;
						if ((dx != 0 || dy != 0) && on_map(x, y) && !explored_rows[y][x]) begin
							s = explored_ring(x, y);
							if (s != 0 && s >= best) begin
								best = s;
								a.next_x = POS_W'(x);
								a.next_y = POS_W'(y);
							end
						end
					end
				end
				if (best != 0) begin
					a.found = 1'b1;
					a.best_score = SCORE_W'(best);
				end
			end
			default: ;
		endcase
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t want, got;
		if (!arst_n) begin
			clear_explored();
			expected_answers.delete();
			pending = 0;
			fail_count = 0;
		end else begin
			if (res.valid && res.ready) begin
				got.found      = res.found;
				got.next_x     = res.next_x;
				got.next_y     = res.next_y;
				got.best_score = res.best_score;
				if (expected_answers.size() == 0) begin
					$display("%0t: unexpected result word: found=%0d x=%0d y=%0d score=%0d",
						$time, got.found, got.next_x, got.next_y, got.best_score);
					fail_count++;
				end else begin
					want = expected_answers.pop_front();
					if (want.found !== got.found || want.next_x !== got.next_x ||
							want.next_y !== got.next_y || want.best_score !== got.best_score) begin
						$display("%0t: mismatch: expected found=%0d x=%0d y=%0d score=%0d, actual found=%0d x=%0d y=%0d score=%0d",
							$time, want.found, want.next_x, want.next_y, want.best_score,
							got.found, got.next_x, got.next_y, got.best_score);
						fail_count++;
					end
				end
			end
			if (req.valid && req.ready)
				expected_answers.push_back(serve_request(req_t'(req.req_type),
					int'(req.cell_x), int'(req.cell_y)));
			pending = expected_answers.size();
		end
	end

endmodule

// ===== sim/frontier_cell_selector_tb.sv =====
`timescale 1ns / 1ps
// Testbench top of the frontier cell selector: clock, reset, request stimulus and
// result back-pressure; the verdict comes from frontier_cell_selector_checker.
// Depends on fcs_pkg, fcs_req_if, fcs_res_if and the block itself.
module frontier_cell_selector_tb;
	import fcs_pkg::*;

	localparam int LIMIT       = 200000;
	localparam int HOLD_CYCLES = 400;
	localparam int BURST       = 24;
	localparam int PHASE_WORDS = 125;

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   stall_pct;
	int   cycle_count;
	int   pending;
	int   fail_count;
	int   cur_x;
	int   cur_y;
	bit   hold_request;

	fcs_req_if req_if();
	fcs_res_if res_if();

	frontier_cell_selector u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.res    (res_if)
	);

	frontier_cell_selector_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_if),
		.res        (res_if),
		.pending    (pending),
		.fail_count (fail_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// result side: random stalls, or one long hold-off on request
	initial begin
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				res_if.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_request = 1'b0;
			end else begin
				res_if.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic send_word(input req_t kind, input int x, input int y);
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.valid    <= 1'b1;
		req_if.req_type <= kind;
		req_if.cell_x   <= POS_W'(x);
		req_if.cell_y   <= POS_W'(y);
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		req_if.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	// mostly marks and plans around a wandering cursor, some anywhere
	task automatic send_random();
		int pick, x, y;
		pick = $urandom_range(99);
		if ($urandom_range(29) == 0) begin
			cur_x = $urandom_range(GRID_DIM - 1);
			cur_y = $urandom_range(GRID_DIM - 1);
		end
		if ($urandom_range(99) < 70) begin
			x = cur_x + int'($urandom_range(4)) - 2;
			y = cur_y + int'($urandom_range(4)) - 2;
			if (x < 0) x = 0;
			if (y < 0) y = 0;
			if (x > GRID_DIM - 1) x = GRID_DIM - 1;
			if (y > GRID_DIM - 1) y = GRID_DIM - 1;
		end else begin
			x = $urandom_range(15);
			y = $urandom_range(15);
		end
		if (pick < 2) begin
			send_word(REQ_RESTART, x, y);
		end else if (pick < 6) begin
			send_word(REQ_NOP, x, y);
		end else if (pick < 52) begin
			send_word(REQ_MARK, x, y);
			cur_x = x;
			cur_y = y;
		end else begin
			send_word(REQ_PLAN, x, y);
		end
	endtask

	initial begin
		int dx, dy, phase;
		arst_n          = 1'b0;
		req_if.valid    = 1'b0;
		req_if.req_type = REQ_NOP;
		req_if.cell_x   = '0;
		req_if.cell_y   = '0;
		send_idle_pct   = 0;
		stall_pct       = 0;
		hold_request    = 1'b0;
		cur_x           = 0;
		cur_y           = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_word(REQ_PLAN, 0, 0);
		send_word(REQ_PLAN, 5, 5);
		send_word(REQ_NOP, 15, 15);
		send_word(REQ_MARK, 15, 15);
		send_word(REQ_PLAN, 15, 15);
		send_word(REQ_MARK, 15, 0);
		send_word(REQ_MARK, 0, 15);
		send_word(REQ_PLAN, 14, 1);
		send_word(REQ_PLAN, 1, 14);
		for (dy = -1; dy <= 1; dy++) begin
			for (dx = -1; dx <= 1; dx++) begin
				if (dx != 0 || dy != 0)
					send_word(REQ_MARK, 8 + dx, 8 + dy);
			end
		end
		send_word(REQ_PLAN, 7, 7);
		send_word(REQ_PLAN, 8, 8);
		send_word(REQ_NOP, 0, 0);
		send_word(REQ_RESTART, 10, 10);
		send_word(REQ_PLAN, 8, 8);
		send_word(REQ_PLAN, 0, 0);
		send_word(REQ_MARK, 0, 1);
		send_word(REQ_PLAN, 0, 0);
		drain();

		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 51;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 51;
				end
				default: begin
					send_idle_pct = 36;
					stall_pct = 36;
				end
			endcase
			repeat (PHASE_WORDS) send_random();
			drain();
			if (phase == 0 || phase == 2) begin
				send_idle_pct = 0;
				hold_request = 1'b1;
				repeat (BURST) send_random();
				drain();
			end
		end

		repeat (20) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/fcs_pkg.sv
sv/fcs_req_if.sv
sv/fcs_res_if.sv
sv/fcs_map_store.sv
sv/frontier_cell_selector.sv
sv/fcs_checker.sv
sim/frontier_cell_selector_checker.sv
sim/frontier_cell_selector_tb.sv
